>>> src/scsp_pkg.sv
// shared types and constants for the shader container stream parser
`timescale 1ns / 1ps
package scsp_pkg;

   localparam logic [31:0] MAGIC_WORD = 32'h6178_6772;
   localparam int          SKIP_BYTES = 5;

   localparam logic [1:0] KIND_RECORD = 2'd0;
   localparam logic [1:0] KIND_CHAR   = 2'd1;
   localparam logic [1:0] KIND_CODE   = 2'd2;
   localparam logic [1:0] KIND_STATUS = 2'd3;

   localparam logic [1:0] STATUS_COMPLETE  = 2'd0;
   localparam logic [1:0] STATUS_BAD_MAGIC = 2'd1;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

   localparam logic [1:0] FINISHED_NONE     = 2'd0;
   localparam logic [1:0] FINISHED_COMPLETE = 2'd1;
   localparam logic [1:0] FINISHED_BAD      = 2'd2;

   typedef enum logic [3:0] {
      PH_MAGIC,
      PH_VCOUNT,
      PH_VARCOUNT,
      PH_VTYPE,
      PH_VSLOT,
      PH_VTAG,
      PH_NAMELEN,
      PH_NAME,
      PH_SIZES,
      PH_CODE,
      PH_PCOUNT,
      PH_SKIP,
      PH_DONE
   } phase_type;

   // which results one input beat produced, in delivery order
   typedef struct packed {
      logic has_char;
      logic has_rec;
      logic has_code;
      logic has_status;
   } flags_type;

   // everything the back end needs to rebuild the results of one input beat
   typedef struct packed {
      flags_type   flags;
      logic        is_pixel;
      logic [7:0]  fragment_index;
      logic [7:0]  variable_index;
      logic [7:0]  var_type;
      logic [7:0]  var_slot;
      logic [15:0] var_tag;
      logic [7:0]  name_length;
      logic [7:0]  data_byte;
      logic [15:0] byte_offset;
      logic        last;
      logic [1:0]  status;
   } bundle_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic        is_pixel;
      logic [7:0]  fragment_index;
      logic [7:0]  variable_index;
      logic [7:0]  var_type;
      logic [7:0]  var_slot;
      logic [15:0] var_tag;
      logic [7:0]  name_length;
      logic [7:0]  out_byte;
      logic [15:0] byte_offset;
      logic        last;
      logic [1:0]  status;
   } rsp_type;

endpackage

>>> src/scsp_req_if.sv
// input byte channel
`timescale 1ns / 1ps
interface scsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_file;

   modport source (output valid, output in_byte, output end_of_file, input ready);
   modport sink (input valid, input in_byte, input end_of_file, output ready);
endinterface

>>> src/scsp_rsp_if.sv
// result channel
`timescale 1ns / 1ps
interface scsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic        is_pixel;
   logic [7:0]  fragment_index;
   logic [7:0]  variable_index;
   logic [7:0]  var_type;
   logic [7:0]  var_slot;
   logic [15:0] var_tag;
   logic [7:0]  name_length;
   logic [7:0]  out_byte;
   logic [15:0] byte_offset;
   logic        last;
   logic [1:0]  status;

   modport source (output valid, output kind, output is_pixel, output fragment_index,
                   output variable_index, output var_type, output var_slot,
                   output var_tag, output name_length, output out_byte,
                   output byte_offset, output last, output status, input ready);
   modport sink (input valid, input kind, input is_pixel, input fragment_index,
                 input variable_index, input var_type, input var_slot,
                 input var_tag, input name_length, input out_byte,
                 input byte_offset, input last, input status, output ready);
endinterface

>>> src/scsp_front.sv
// parse state machine: takes one byte a beat and pushes a bundle of results
`timescale 1ns / 1ps
module scsp_front
   import scsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   scsp_req_if.sink   req,
   input  logic       q_full,
   output logic       q_push,
   output bundle_type q_data
);

   phase_type   phase_ff, phase_in;
   logic [31:0] magic_ff, magic_in;
   logic [2:0]  field_cnt_ff, field_cnt_in;
   logic        pixel_ff, pixel_in;
   logic [7:0]  frags_left_ff, frags_left_in;
   logic [7:0]  frag_num_ff, frag_num_in;
   logic [7:0]  vars_left_ff, vars_left_in;
   logic [7:0]  var_num_ff, var_num_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  slot_ff, slot_in;
   logic [15:0] tag_ff, tag_in;
   logic [7:0]  name_rem_ff, name_rem_in;
   logic [7:0]  name_total_ff, name_total_in;
   logic [15:0] code_size_ff, code_size_in;
   logic [15:0] position_ff, position_in;
   logic [1:0]  finished_ff, finished_in;

   logic        fire;
   logic [7:0]  b;
   logic [31:0] magic_next;
   logic [7:0]  frags_dec;
   logic [7:0]  vars_dec;
   logic [7:0]  start_count;
   logic        final_char;
   logic        final_byte;
   bundle_type  bundle;

   assign req.ready = !q_full;
   assign fire      = req.valid && !q_full;
   assign b         = req.in_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_MAGIC;
         magic_ff      <= '0;
         field_cnt_ff  <= '0;
         pixel_ff      <= 1'b0;
         frags_left_ff <= '0;
         frag_num_ff   <= '0;
         vars_left_ff  <= '0;
         var_num_ff    <= '0;
         type_ff       <= '0;
         slot_ff       <= '0;
         tag_ff        <= '0;
         name_rem_ff   <= '0;
         name_total_ff <= '0;
         code_size_ff  <= '0;
         position_ff   <= '0;
         finished_ff   <= FINISHED_NONE;
      end else begin
         phase_ff      <= phase_in;
         magic_ff      <= magic_in;
         field_cnt_ff  <= field_cnt_in;
         pixel_ff      <= pixel_in;
         frags_left_ff <= frags_left_in;
         frag_num_ff   <= frag_num_in;
         vars_left_ff  <= vars_left_in;
         var_num_ff    <= var_num_in;
         type_ff       <= type_in;
         slot_ff       <= slot_in;
         tag_ff        <= tag_in;
         name_rem_ff   <= name_rem_in;
         name_total_ff <= name_total_in;
         code_size_ff  <= code_size_in;
         position_ff   <= position_in;
         finished_ff   <= finished_in;
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      magic_in      = magic_ff;
      field_cnt_in  = field_cnt_ff;
      pixel_in      = pixel_ff;
      frags_left_in = frags_left_ff;
      frag_num_in   = frag_num_ff;
      vars_left_in  = vars_left_ff;
      var_num_in    = var_num_ff;
      type_in       = type_ff;
      slot_in       = slot_ff;
      tag_in        = tag_ff;
      name_rem_in   = name_rem_ff;
      name_total_in = name_total_ff;
      code_size_in  = code_size_ff;
      position_in   = position_ff;
      finished_in   = finished_ff;

      magic_next  = {b, magic_ff[31:8]};
      frags_dec   = frags_left_ff - 8'd1;
      vars_dec    = vars_left_ff - 8'd1;
      start_count = (phase_ff == PH_VCOUNT) ? b : frags_left_ff;
      final_char  = (name_rem_ff <= 8'd1);
      final_byte  = ({1'b0, position_ff} + 17'd1) >= {1'b0, code_size_ff};

      bundle                = '0;
      bundle.is_pixel       = pixel_ff;
      bundle.fragment_index = frag_num_ff;
      bundle.variable_index = var_num_ff;
      bundle.var_type       = type_ff;
      bundle.var_slot       = slot_ff;
      bundle.var_tag        = tag_ff;
      bundle.data_byte      = b;
      bundle.byte_offset    = position_ff;

      if (fire) begin
         unique case (phase_ff)
            PH_MAGIC: begin
               magic_in     = magic_next;
               field_cnt_in = field_cnt_ff + 3'd1;
               if (field_cnt_ff >= 3'd3) begin
                  field_cnt_in = '0;
                  if (magic_next == MAGIC_WORD) begin
                     phase_in = PH_VCOUNT;
                  end else begin
                     phase_in                 = PH_DONE;
                     finished_in              = FINISHED_BAD;
                     bundle.flags.has_status  = 1'b1;
                     bundle.status            = STATUS_BAD_MAGIC;
                  end
               end
            end
            PH_VCOUNT, PH_SKIP: begin
               // skip bytes count up first, then open the pixel section; a vertex count opens the vertex section
               if (phase_ff == PH_SKIP) begin
                  field_cnt_in = field_cnt_ff + 3'd1;
               end
               if (phase_ff == PH_VCOUNT || field_cnt_ff >= 3'(SKIP_BYTES - 1)) begin
                  field_cnt_in  = '0;
                  frags_left_in = start_count;
                  frag_num_in   = '0;
                  pixel_in      = (phase_ff == PH_SKIP);
                  if (start_count != 8'd0) begin
                     phase_in = PH_VARCOUNT;
                  end else if (phase_ff == PH_VCOUNT) begin
                     phase_in = PH_PCOUNT;
                  end else begin
                     phase_in                = PH_DONE;
                     finished_in             = FINISHED_COMPLETE;
                     bundle.flags.has_status = 1'b1;
                     bundle.status           = STATUS_COMPLETE;
                  end
               end
            end
            PH_PCOUNT: begin
               frags_left_in = (b != 8'd0) ? b - 8'd1 : 8'd0;
               field_cnt_in  = '0;
               phase_in      = PH_SKIP;
            end
            PH_VARCOUNT: begin
               vars_left_in = b;
               var_num_in   = '0;
               if (b != 8'd0) begin
                  phase_in = PH_VTYPE;
               end else begin
                  phase_in     = PH_SIZES;
                  field_cnt_in = '0;
               end
            end
            PH_VTYPE: begin
               type_in  = b;
               phase_in = PH_VSLOT;
            end
            PH_VSLOT: begin
               slot_in      = b;
               phase_in     = PH_VTAG;
               field_cnt_in = '0;
            end
            PH_VTAG: begin
               if (field_cnt_ff == 3'd0) begin
                  tag_in       = {8'd0, b};
                  field_cnt_in = 3'd1;
               end else begin
                  tag_in       = {b, tag_ff[7:0]};
                  field_cnt_in = '0;
                  phase_in     = PH_NAMELEN;
               end
            end
            PH_NAMELEN, PH_NAME: begin
               if (phase_ff == PH_NAMELEN) begin
                  name_total_in = b;
                  name_rem_in   = b;
                  position_in   = '0;
                  phase_in      = PH_NAME;
               end else begin
                  // a zero in the final name position is dropped
                  bundle.flags.has_char = !final_char || (b != 8'd0);
                  position_in           = position_ff + 16'd1;
                  name_rem_in           = name_rem_ff - 8'd1;
               end
               if ((phase_ff == PH_NAMELEN && b == 8'd0) ||
                   (phase_ff == PH_NAME && final_char)) begin
                  bundle.flags.has_rec = 1'b1;
                  if (phase_ff == PH_NAMELEN) begin
                     bundle.name_length = 8'd0;
                  end else begin
                     bundle.name_length = (b == 8'd0) ? name_total_ff - 8'd1 : name_total_ff;
                  end
                  var_num_in   = var_num_ff + 8'd1;
                  vars_left_in = vars_dec;
                  if (vars_dec != 8'd0) begin
                     phase_in = PH_VTYPE;
                  end else begin
                     phase_in     = PH_SIZES;
                     field_cnt_in = '0;
                  end
               end
            end
            PH_SIZES, PH_CODE: begin
               if (phase_ff == PH_SIZES) begin
                  if (field_cnt_ff == 3'd0) begin
                     code_size_in = {8'd0, b};
                  end else if (field_cnt_ff == 3'd1) begin
                     code_size_in = {b, code_size_ff[7:0]};
                  end
                  field_cnt_in = field_cnt_ff + 3'd1;
                  if (field_cnt_ff >= 3'd3) begin
                     field_cnt_in = '0;
                     position_in  = '0;
                     if (code_size_ff[15:8] == 8'd0 && code_size_ff[7:0] == 8'd0 &&
                         field_cnt_ff != 3'd1) begin
                        phase_in = PH_DONE; // overwritten below by the fragment close
                     end else begin
                        phase_in = PH_CODE;
                     end
                  end
               end else begin
                  bundle.flags.has_code = 1'b1;
                  bundle.last           = final_byte;
                  position_in           = position_ff + 16'd1;
               end
               // close the fragment on an empty bytecode or its final byte
               if ((phase_ff == PH_SIZES && field_cnt_ff >= 3'd3 && code_size_ff == 16'd0) ||
                   (phase_ff == PH_CODE && final_byte)) begin
                  frag_num_in   = frag_num_ff + 8'd1;
                  frags_left_in = frags_dec;
                  if (frags_dec != 8'd0) begin
                     phase_in = PH_VARCOUNT;
                  end else if (!pixel_ff) begin
                     phase_in = PH_PCOUNT;
                  end else begin
                     phase_in                = PH_DONE;
                     finished_in             = FINISHED_COMPLETE;
                     bundle.flags.has_status = 1'b1;
                     bundle.status           = STATUS_COMPLETE;
                  end
               end
            end
            default: begin
            end
         endcase

         if (req.end_of_file) begin
            if (finished_in == FINISHED_NONE) begin
               bundle.flags.has_status = 1'b1;
               bundle.status           = STATUS_TRUNCATED;
            end
            phase_in      = PH_MAGIC;
            magic_in      = '0;
            field_cnt_in  = '0;
            pixel_in      = 1'b0;
            frags_left_in = '0;
            frag_num_in   = '0;
            vars_left_in  = '0;
            var_num_in    = '0;
            type_in       = '0;
            slot_in       = '0;
            tag_in        = '0;
            name_rem_in   = '0;
            name_total_in = '0;
            code_size_in  = '0;
            position_in   = '0;
            finished_in   = FINISHED_NONE;
         end
      end

      q_data = bundle;
      q_push = fire && (bundle.flags != '0);
   end

endmodule

>>> src/scsp_queue.sv
// short bundle queue between the parser and the result serializer
`timescale 1ns / 1ps
module scsp_queue
   import scsp_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  bundle_type push_data,
   output logic       full,
   input  logic       pop,
   output bundle_type pop_data,
   output logic       empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   bundle_type       entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> src/scsp_back.sv
// result serializer: unpacks each bundle into beats behind an output register
`timescale 1ns / 1ps
module scsp_back
   import scsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  bundle_type q_data,
   input  logic       q_empty,
   output logic       q_pop,
   scsp_rsp_if.source rsp
);

   bundle_type cur_ff, cur_in;
   flags_type  flags_ff, flags_in;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff, out_in;

   logic       out_free;
   logic       send;
   flags_type  pick;
   flags_type  flags_left;
   rsp_type    beat;

   assign out_free = !out_valid_ff || rsp.ready;
   assign send     = out_free && (flags_ff != '0);

   always_comb begin
      pick = '0;
      beat = '0;
      beat.is_pixel       = cur_ff.is_pixel;
      beat.fragment_index = cur_ff.fragment_index;
      priority if (flags_ff.has_char) begin
         pick.has_char       = 1'b1;
         beat.kind           = KIND_CHAR;
         beat.variable_index = cur_ff.variable_index;
         beat.out_byte       = cur_ff.data_byte;
         beat.byte_offset    = cur_ff.byte_offset;
      end else if (flags_ff.has_rec) begin
         pick.has_rec        = 1'b1;
         beat.kind           = KIND_RECORD;
         beat.variable_index = cur_ff.variable_index;
         beat.var_type       = cur_ff.var_type;
         beat.var_slot       = cur_ff.var_slot;
         beat.var_tag        = cur_ff.var_tag;
         beat.name_length    = cur_ff.name_length;
      end else if (flags_ff.has_code) begin
         pick.has_code       = 1'b1;
         beat.kind           = KIND_CODE;
         beat.out_byte       = cur_ff.data_byte;
         beat.byte_offset    = cur_ff.byte_offset;
         beat.last           = cur_ff.last;
      end else begin
         pick.has_status     = flags_ff.has_status;
         beat                = '0;
         beat.kind           = KIND_STATUS;
         beat.status         = cur_ff.status;
      end

      flags_left = send ? (flags_ff & ~pick) : flags_ff;
      // refill as the last pending beat of the current bundle goes out
      q_pop      = (flags_left == '0) && !q_empty;
      cur_in     = q_pop ? q_data : cur_ff;
      flags_in   = q_pop ? q_data.flags : flags_left;

      out_valid_in = send ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_ff);
      out_in       = send ? beat : out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         flags_ff     <= flags_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      out_ff <= out_in;
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.kind           = out_ff.kind;
   assign rsp.is_pixel       = out_ff.is_pixel;
   assign rsp.fragment_index = out_ff.fragment_index;
   assign rsp.variable_index = out_ff.variable_index;
   assign rsp.var_type       = out_ff.var_type;
   assign rsp.var_slot       = out_ff.var_slot;
   assign rsp.var_tag        = out_ff.var_tag;
   assign rsp.name_length    = out_ff.name_length;
   assign rsp.out_byte       = out_ff.out_byte;
   assign rsp.byte_offset    = out_ff.byte_offset;
   assign rsp.last           = out_ff.last;
   assign rsp.status         = out_ff.status;

endmodule

>>> src/shader_container_stream_parser.sv
// top level of the shader container stream parser
//
//   channel   direction  beat
//   req_bus   in         in_byte, end_of_file: one file byte
//   rsp_bus   out        kind and fields of one result (record, char, code byte, status)
//
// one input byte a cycle while the bundle queue has room; an input byte yields
// zero to three results, and the output side sends one result a cycle while the
// receiver is ready, so a byte that yields k results takes k output beats.
// reset is synchronous and clears the parser, the queue and the output register.
// the output stalls only the back end; the parser keeps going until the queue fills.
`timescale 1ns / 1ps
module shader_container_stream_parser
   import scsp_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   scsp_req_if.sink   req_bus,
   scsp_rsp_if.source rsp_bus
);

   logic       q_push;
   logic       q_full;
   logic       q_pop;
   logic       q_empty;
   bundle_type q_push_data;
   bundle_type q_pop_data;

   scsp_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_bus),
      .q_full (q_full),
      .q_push (q_push),
      .q_data (q_push_data)
   );

   scsp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   scsp_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_data  (q_pop_data),
      .q_empty (q_empty),
      .q_pop   (q_pop),
      .rsp     (rsp_bus)
   );

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("bundle pushed into a full queue");

   a_pop_data: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("bundle popped from an empty queue");

   a_push_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_push_data.flags != '0))
      else $error("empty bundle pushed");

endmodule

>>> verif/shader_container_stream_parser_test.sv
// byte-stream testbench for the shader container parser: predicted results checked in order
`timescale 1ns / 1ps
module shader_container_stream_parser_test;
   import scsp_pkg::*;

   localparam int TARGET_BYTES = 430;
   localparam int HOLD_CYCLES  = 200;
   localparam int DRAIN_CYCLES = 20;

   class parse_scoreboard;
      rsp_type     expected_results[$];
      int          mismatches;
      // parser state
      phase_type   phase;
      logic [31:0] magic_shift;
      logic [2:0]  field_counter;
      logic        in_pixel;
      logic [7:0]  frags_left;
      logic [7:0]  frag_num;
      logic [7:0]  vars_left;
      logic [7:0]  var_num;
      logic [7:0]  held_type;
      logic [7:0]  held_slot;
      logic [15:0] held_tag;
      logic [7:0]  name_left;
      logic [7:0]  name_total;
      logic [15:0] code_size;
      logic [15:0] position;
      logic [1:0]  finished;

      function new();
         mismatches = 0;
         clear_parser();
      endfunction

      function void clear_parser();
         phase         = PH_MAGIC;
         magic_shift   = '0;
         field_counter = '0;
         in_pixel      = 1'b0;
         frags_left    = '0;
         frag_num      = '0;
         vars_left     = '0;
         var_num       = '0;
         held_type     = '0;
         held_slot     = '0;
         held_tag      = '0;
         name_left     = '0;
         name_total    = '0;
         code_size     = '0;
         position      = '0;
         finished      = FINISHED_NONE;
      endfunction

      function void add_status(logic [1:0] st);
         rsp_type r;
         r        = '0;
         r.kind   = KIND_STATUS;
         r.status = st;
         expected_results = {expected_results, r};
      endfunction

      // shared tail of a fragment count or a fragment end
      function void pick_next_section();
         if (frags_left != 0) begin
            phase = PH_VARCOUNT;
         end else if (!in_pixel) begin
            phase = PH_PCOUNT;
         end else begin
            phase    = PH_DONE;
            finished = FINISHED_COMPLETE;
            add_status(STATUS_COMPLETE);
         end
      endfunction

      function void open_section(logic [7:0] count, logic pixel);
         frags_left = count;
         frag_num   = '0;
         in_pixel   = pixel;
         pick_next_section();
      endfunction

      function void close_fragment();
         frag_num   = frag_num + 8'd1;
         frags_left = frags_left - 8'd1;
         pick_next_section();
      endfunction

      function void close_variable(logic [7:0] len);
         rsp_type r;
         r                = '0;
         r.kind           = KIND_RECORD;
         r.is_pixel       = in_pixel;
         r.fragment_index = frag_num;
         r.variable_index = var_num;
         r.var_type       = held_type;
         r.var_slot       = held_slot;
         r.var_tag        = held_tag;
         r.name_length    = len;
         expected_results = {expected_results, r};
         var_num   = var_num + 8'd1;
         vars_left = vars_left - 8'd1;
         if (vars_left != 0) begin
            phase = PH_VTYPE;
         end else begin
            phase         = PH_SIZES;
            field_counter = '0;
         end
      endfunction

      // advance the parse by one accepted byte and queue what it yields
      function void note_byte(logic [7:0] b, logic eof);
         rsp_type r;
         logic    last_char;
         logic    last_byte;
         case (phase)
            PH_MAGIC: begin
               magic_shift   = {b, magic_shift[31:8]};
               field_counter = field_counter + 3'd1;
               if (field_counter >= 3'd4) begin
                  field_counter = '0;
                  if (magic_shift == MAGIC_WORD) begin
                     phase = PH_VCOUNT;
                  end else begin
                     phase    = PH_DONE;
                     finished = FINISHED_BAD;
                     add_status(STATUS_BAD_MAGIC);
                  end
               end
            end
            PH_VCOUNT: open_section(b, 1'b0);
            PH_PCOUNT: begin
               // stored as count + 1, zero behaves like one
               frags_left    = (b != 0) ? b - 8'd1 : 8'd0;
               field_counter = '0;
               phase         = PH_SKIP;
            end
            PH_SKIP: begin
               field_counter = field_counter + 3'd1;
               if (field_counter >= 3'(SKIP_BYTES)) begin
                  field_counter = '0;
                  open_section(frags_left, 1'b1);
               end
            end
            PH_VARCOUNT: begin
               vars_left = b;
               var_num   = '0;
               if (b != 0) begin
                  phase = PH_VTYPE;
               end else begin
                  phase         = PH_SIZES;
                  field_counter = '0;
               end
            end
            PH_VTYPE: begin
               held_type = b;
               phase     = PH_VSLOT;
            end
            PH_VSLOT: begin
               held_slot     = b;
               phase         = PH_VTAG;
               field_counter = '0;
            end
            PH_VTAG: begin
               if (field_counter == 0) begin
                  held_tag      = {8'h00, b};
                  field_counter = 3'd1;
               end else begin
                  held_tag      = {b, held_tag[7:0]};
                  field_counter = '0;
                  phase         = PH_NAMELEN;
               end
            end
            PH_NAMELEN: begin
               name_total = b;
               name_left  = b;
               position   = '0;
               if (b == 0) close_variable(8'd0);
               else phase = PH_NAME;
            end
            PH_NAME: begin
               last_char = name_left <= 8'd1;
               // a zero in the final name position is dropped
               if (!last_char || b != 0) begin
                  r                = '0;
                  r.kind           = KIND_CHAR;
                  r.is_pixel       = in_pixel;
                  r.fragment_index = frag_num;
                  r.variable_index = var_num;
                  r.out_byte       = b;
                  r.byte_offset    = position;
                  expected_results = {expected_results, r};
               end
               position  = position + 16'd1;
               name_left = name_left - 8'd1;
               if (last_char) close_variable((b == 0) ? name_total - 8'd1 : name_total);
            end
            PH_SIZES: begin
               if (field_counter == 0) code_size = {8'h00, b};
               else if (field_counter == 1) code_size = {b, code_size[7:0]};
               field_counter = field_counter + 3'd1;
               if (field_counter >= 3'd4) begin
                  field_counter = '0;
                  position      = '0;
                  if (code_size == 0) close_fragment();
                  else phase = PH_CODE;
               end
            end
            PH_CODE: begin
               last_byte        = ({1'b0, position} + 17'd1) >= {1'b0, code_size};
               r                = '0;
               r.kind           = KIND_CODE;
               r.is_pixel       = in_pixel;
               r.fragment_index = frag_num;
               r.out_byte       = b;
               r.byte_offset    = position;
               r.last           = last_byte;
               expected_results = {expected_results, r};
               position = position + 16'd1;
               if (last_byte) close_fragment();
            end
            default: ;
         endcase
         if (eof) begin
            if (finished == FINISHED_NONE) add_status(STATUS_TRUNCATED);
            clear_parser();
         end
      endfunction

      function string show(rsp_type r);
         return $sformatf({"kind=%0d pix=%0d frag=%0d var=%0d type=%h slot=%h tag=%h ",
                           "len=%0d byte=%h off=%0d last=%0d status=%0d"},
                          r.kind, r.is_pixel, r.fragment_index, r.variable_index,
                          r.var_type, r.var_slot, r.var_tag, r.name_length,
                          r.out_byte, r.byte_offset, r.last, r.status);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result: %s", show(got));
         end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: expected %s", show(want));
                  $display("          actual   %s", show(got));
               end
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   scsp_req_if req_bus ();
   scsp_rsp_if rsp_bus ();

   shader_container_stream_parser dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   parse_scoreboard sb = new();

   int         sent = 0;
   bit         quiet = 1'b0;
   bit         hold_request = 1'b0;
   bit         hold_done = 1'b0;
   logic [7:0] file[$];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("Test completed with failures");
      $finish;
   end

   task automatic send_byte(input logic [7:0] data, input logic eof);
      if (!quiet) begin
         while ($urandom_range(0, 99) < 17) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_bus.valid       <= 1'b1;
      req_bus.in_byte     <= data;
      req_bus.end_of_file <= eof;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_byte(data, eof);
      sent++;
      quiet = (sent >= 120 && sent < 220);
      if (sent == 300) hold_request = 1'b1;
   endtask

   task automatic send_file();
      for (int i = 0; i < file.size(); i++) send_byte(file[i], i == file.size() - 1);
   endtask

   function automatic void add_fragment(ref logic [7:0] f[$], input bit big);
      int vars;
      int len;
      int size;
      vars = $urandom_range(0, 2);
      f = {f, 8'(vars)};
      for (int v = 0; v < vars; v++) begin
         repeat (4) f = {f, 8'($urandom)};
         len = $urandom_range(0, 4);
         f = {f, 8'(len)};
         for (int i = 0; i < len; i++) begin
            if ((i == len - 1 && $urandom_range(0, 1) == 0) || $urandom_range(0, 9) == 0)
               f = {f, 8'h00};
            else
               f = {f, 8'($urandom)};
         end
      end
      size = big ? $urandom_range(256, 262) : $urandom_range(0, 6);
      f = {f, size[7:0]};
      f = {f, size[15:8]};
      repeat (2) f = {f, 8'($urandom)};
      repeat (size) f = {f, 8'($urandom)};
   endfunction

   function automatic void build_file(ref logic [7:0] f[$], input bit big);
      int vcount;
      int pstored;
      f = {};
      for (int i = 0; i < 4; i++) f = {f, MAGIC_WORD[8*i +: 8]};
      vcount = big ? 1 : $urandom_range(0, 2);
      f = {f, 8'(vcount)};
      for (int i = 0; i < vcount; i++) add_fragment(f, big && i == 0);
      pstored = $urandom_range(0, 3);
      f = {f, 8'(pstored)};
      repeat (SKIP_BYTES) f = {f, 8'($urandom)};
      for (int i = 1; i < pstored; i++) add_fragment(f, 1'b0);
   endfunction

   // result side: random backpressure plus one long hold-off
   initial begin
      rsp_type got;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got.kind           = rsp_bus.kind;
            got.is_pixel       = rsp_bus.is_pixel;
            got.fragment_index = rsp_bus.fragment_index;
            got.variable_index = rsp_bus.variable_index;
            got.var_type       = rsp_bus.var_type;
            got.var_slot       = rsp_bus.var_slot;
            got.var_tag        = rsp_bus.var_tag;
            got.name_length    = rsp_bus.name_length;
            got.out_byte       = rsp_bus.out_byte;
            got.byte_offset    = rsp_bus.byte_offset;
            got.last           = rsp_bus.last;
            got.status         = rsp_bus.status;
            sb.check_result(got);
         end
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_bus.ready <= quiet || $urandom_range(0, 99) >= 17;
         end
      end
   end

   initial begin
      int mode;
      int file_count;
      file_count = 0;
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.in_byte     <= 8'h00;
      req_bus.end_of_file <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // all-ones magic is rejected on its fourth byte
      file = {8'hFF, 8'hFF, 8'hFF, 8'hFF};
      send_file();
      // one vertex fragment, name of a single zero, pixel count stored as zero
      file = {MAGIC_WORD[7:0], MAGIC_WORD[15:8], MAGIC_WORD[23:16], MAGIC_WORD[31:24],
              8'h01, 8'h01, 8'hFF, 8'h00, 8'h34, 8'h12, 8'h01, 8'h00,
              8'h01, 8'h00, 8'hFF, 8'hFF, 8'hAB, 8'h00,
              8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      send_file();

      while (sent < TARGET_BYTES) begin
         build_file(file, file_count == 2);
         mode = $urandom_range(0, 99);
         if (mode < 15) begin
            file = file[0 : $urandom_range(0, file.size() - 2)];
         end else if (mode < 25) begin
            file[$urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
         end else if (mode < 30) begin
            file = {};
            repeat ($urandom_range(1, 8)) file = {file, 8'($urandom)};
         end else if (mode < 45) begin
            // bytes after a complete file are ignored up to end of file
            repeat ($urandom_range(1, 4)) file = {file, 8'($urandom)};
         end
         send_file();
         file_count++;
      end
      req_bus.valid <= 1'b0;

      while (sb.expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_results.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

>>> shader_container_stream_parser.f
src/scsp_pkg.sv
src/scsp_req_if.sv
src/scsp_rsp_if.sv
src/scsp_front.sv
src/scsp_queue.sv
src/scsp_back.sv
src/shader_container_stream_parser.sv
verif/shader_container_stream_parser_test.sv
